/* rtl/plro_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plro_pkg
// types and constants shared by the path length and rotation odometer
// ----------------------------------------------------------------------------
package plro_pkg;

  localparam int POS_W    = 32;
  localparam int YAW_W    = 16;
  localparam int THR_W    = 16;
  localparam int LEN_W    = 48;
  localparam int ROT_W    = 40;
  localparam int DIST_W   = 33;
  localparam int RAD_W    = 66;
  localparam int REM_W    = 36;

  // one result bit per radicand bit pair
  localparam int ROOT_STEPS = RAD_W / 2;
  localparam int STEP_W     = $clog2(ROOT_STEPS);

  localparam logic [THR_W-1:0] THR_RESET = 16'd7;

  localparam logic [YAW_W-1:0] HALF_TURN = 16'h8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_COMMIT
  } plro_state_t;

  typedef struct packed {
    logic load;
    logic diff;
    logic square;
    logic sum;
    logic root_step;
    logic commit;
  } plro_cmd_t;

  typedef struct packed {
    logic route;
  } plro_sts_t;

endpackage

/* rtl/plro_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plro interfaces
// request channels for pose samples in and totals out
// ----------------------------------------------------------------------------
interface plro_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic        [15:0] pose_yaw;

  modport source (output valid, action, pose_x, pose_y, pose_yaw, input ready);
  modport sink   (input valid, action, pose_x, pose_y, pose_yaw, output ready);
endinterface

interface plro_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] total_length;
  logic [39:0] total_rotation;
  logic        sample_taken;

  modport source (output valid, total_length, total_rotation, sample_taken, input ready);
  modport sink   (input valid, total_length, total_rotation, sample_taken, output ready);
endinterface

/* rtl/plro_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plro_ctrl
// sequencer for one request: difference, square, sum, root iterations, commit
// ----------------------------------------------------------------------------
module plro_ctrl
  import plro_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  plro_sts_t   sts,
  output plro_cmd_t   cmd
);

  plro_state_t       state, state_next;
  logic [STEP_W-1:0] step_cnt;
  logic              out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_DIFF;
      ST_DIFF:   state_next = sts.route ? ST_COMMIT : ST_SQUARE;
      ST_SQUARE: state_next = ST_SUM;
      ST_SUM:    state_next = ST_ROOT;
      ST_ROOT:   if (step_cnt == STEP_W'(ROOT_STEPS - 1)) state_next = ST_COMMIT;
      ST_COMMIT: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DIFF:   cmd.diff      = 1'b1;
      ST_SQUARE: cmd.square    = 1'b1;
      ST_SUM:    cmd.sum       = 1'b1;
      ST_ROOT:   cmd.root_step = 1'b1;
      ST_COMMIT: cmd.commit    = out_free;
      default:   cmd           = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.sum) begin
        step_cnt <= '0;
      end else if (cmd.root_step) begin
        step_cnt <= step_cnt + 1'b1;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/plro_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plro_dp
// step distance, bit-pair square root, yaw difference and saturating totals
// ----------------------------------------------------------------------------
module plro_dp
  import plro_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  plro_cmd_t               cmd,
  output plro_sts_t               sts,
  input  logic                    cfg_wr_en,
  input  logic [THR_W-1:0]        cfg_wr_data,
  input  logic                    in_action,
  input  logic signed [POS_W-1:0] in_pose_x,
  input  logic signed [POS_W-1:0] in_pose_y,
  input  logic [YAW_W-1:0]        in_pose_yaw,
  output logic [LEN_W-1:0]        total_length,
  output logic [ROT_W-1:0]        total_rotation,
  output logic                    sample_taken
);

  logic [THR_W-1:0]  threshold;
  logic [POS_W-1:0]  last_x, last_y;
  logic [YAW_W-1:0]  last_yaw;
  logic [LEN_W-1:0]  length_sum;
  logic [ROT_W-1:0]  rotation_sum;

  logic              act;
  logic [POS_W-1:0]  px, py;
  logic [YAW_W-1:0]  pyaw;
  logic [POS_W-1:0]  ax, ay;
  logic [2*POS_W-1:0] sx, sy;
  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [DIST_W-1:0] root;

  logic [POS_W:0]    dx, dy;
  logic [REM_W-1:0]  rem_shift, trial;
  logic              fits;
  logic [YAW_W-1:0]  dyaw, rot;
  logic [LEN_W:0]    len_add;
  logic [ROT_W:0]    rot_add;
  logic              counted;

  assign sts.route = act;

  // exact 33-bit differences, magnitude fits 32 bits
  assign dx = {px[POS_W-1], px} - {last_x[POS_W-1], last_x};
  assign dy = {py[POS_W-1], py} - {last_y[POS_W-1], last_y};

  // one restoring root step per cycle
  assign rem_shift = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial     = {{(REM_W-DIST_W-2){1'b0}}, root, 2'b01};
  assign fits      = rem_shift >= trial;

  // shortest turn, half turn counts as half turn
  assign dyaw = pyaw - last_yaw;
  assign rot  = (dyaw <= HALF_TURN) ? dyaw : (YAW_W'(0) - dyaw);

  assign len_add = {1'b0, length_sum} + (LEN_W+1)'(root);
  assign rot_add = {1'b0, rotation_sum} + (ROT_W+1)'(rot);
  assign counted = root > DIST_W'(threshold);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act  <= in_action;
      px   <= in_pose_x;
      py   <= in_pose_y;
      pyaw <= in_pose_yaw;
    end
    if (cmd.diff) begin
      ax <= dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
      ay <= dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
    end
    if (cmd.square) begin
      sx <= ax * ax;
      sy <= ay * ay;
    end
    if (cmd.sum) begin
      rad  <= {1'b0, {1'b0, sx} + {1'b0, sy}};
      rem  <= '0;
      root <= '0;
    end else if (cmd.root_step) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= fits ? (rem_shift - trial) : rem_shift;
      root <= {root[DIST_W-2:0], fits};
    end
  end

  // kept pose, totals and threshold
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THR_RESET;
      last_x       <= '0;
      last_y       <= '0;
      last_yaw     <= '0;
      length_sum   <= '0;
      rotation_sum <= '0;
    end else begin
      if (cfg_wr_en) begin
        threshold <= cfg_wr_data;
      end
      if (cmd.commit) begin
        if (act) begin
          length_sum   <= '0;
          rotation_sum <= '0;
        end else if (counted) begin
          length_sum   <= len_add[LEN_W] ? '1 : len_add[LEN_W-1:0];
          rotation_sum <= rot_add[ROT_W] ? '1 : rot_add[ROT_W-1:0];
          last_x       <= px;
          last_y       <= py;
          last_yaw     <= pyaw;
        end
      end
    end
  end

  // result register, holds until taken
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (act) begin
        total_length   <= '0;
        total_rotation <= '0;
        sample_taken   <= 1'b0;
      end else if (counted) begin
        total_length   <= len_add[LEN_W] ? '1 : len_add[LEN_W-1:0];
        total_rotation <= rot_add[ROT_W] ? '1 : rot_add[ROT_W-1:0];
        sample_taken   <= 1'b1;
      end else begin
        total_length   <= length_sum;
        total_rotation <= rotation_sum;
        sample_taken   <= 1'b0;
      end
    end
  end

endmodule

/* rtl/path_length_rotation_odometer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_length_rotation_odometer
// accumulates travelled distance and heading change from pose samples
// ----------------------------------------------------------------------------
//  channel      dir  handshake      payload
//  pose_in      in   valid/ready    action, pose_x, pose_y, pose_yaw
//  totals_out   out  valid/ready    total_length, total_rotation, sample_taken
//  cfg          in   cfg_wr_en      cfg_wr_data (distance threshold)
//
//  one request at a time: from accept to result register it passes
//  difference, square, sum, 33 square root steps and commit, then idle
//  before the next accept; a new-route request passes difference,
//  commit and idle
//  the 33-step bit-pair square root is the longest part of the sequence
//  the result register lets the next request start while a result waits;
//  commit stalls only if the previous result is still not taken
//  rst is synchronous: totals and kept pose clear, threshold returns to 7
// ----------------------------------------------------------------------------
module path_length_rotation_odometer
  import plro_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [THR_W-1:0]   cfg_wr_data,
  plro_in_if.sink            pose_in,
  plro_out_if.source         totals_out
);

  plro_cmd_t cmd;
  plro_sts_t sts;

  // controller: sequencing, request handshakes, result valid
  plro_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pose_in.valid),
    .in_ready  (pose_in.ready),
    .out_valid (totals_out.valid),
    .out_ready (totals_out.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: distance root, yaw step, saturating totals and result payload
  plro_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_action      (pose_in.action),
    .in_pose_x      (pose_in.pose_x),
    .in_pose_y      (pose_in.pose_y),
    .in_pose_yaw    (pose_in.pose_yaw),
    .total_length   (totals_out.total_length),
    .total_rotation (totals_out.total_rotation),
    .sample_taken   (totals_out.sample_taken)
  );

`ifndef NO_ASSERTIONS
  // a commit always presents a result in the next cycle
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> totals_out.valid)
    else $error("commit did not raise result valid");

  // only one request in flight
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (pose_in.valid && pose_in.ready) |=> !pose_in.ready)
    else $error("accepted a request while busy");

  // a counted sample moved at least one unit, so the length total is nonzero
  a_taken_length: assert property (@(posedge clk) disable iff (rst)
    (totals_out.valid && totals_out.sample_taken) |-> (totals_out.total_length != '0))
    else $error("counted sample with zero length total");

  // commit never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!totals_out.valid || totals_out.ready))
    else $error("result overwritten before taken");
`endif

endmodule

/* verif/plro_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plro_tb_pkg
// request codes and totals record shared by the odometer testbench files
// ----------------------------------------------------------------------------
package plro_tb_pkg;

  import plro_pkg::*;

  typedef enum logic {
    ACT_SAMPLE    = 1'b0,
    ACT_NEW_ROUTE = 1'b1
  } odo_action_t;

  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic [ROT_W-1:0] rotation;
    logic             taken;
  } odo_totals_t;

endpackage

/* verif/plro_totals_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plro_totals_checker
// watches both request channels and the threshold port, keeps its own copy
// of the odometer state and checks each totals request against it
// ----------------------------------------------------------------------------
module plro_totals_checker
  import plro_pkg::*;
  import plro_tb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [THR_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_action,
  input  logic [POS_W-1:0]   in_x,
  input  logic [POS_W-1:0]   in_y,
  input  logic [YAW_W-1:0]   in_yaw,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [LEN_W-1:0]   out_length,
  input  logic [ROT_W-1:0]   out_rotation,
  input  logic               out_taken,
  output int                 fail_total,
  output int                 pending_results
);

  logic [POS_W-1:0] kept_x;
  logic [POS_W-1:0] kept_y;
  logic [YAW_W-1:0] kept_yaw;
  logic [LEN_W-1:0] length_total;
  logic [ROT_W-1:0] rotation_total;
  logic [THR_W-1:0] threshold;

  odo_totals_t expected_totals[$];

  // floor square root, one result bit at a time from the top
  function automatic logic [DIST_W-1:0] floor_root(input logic [RAD_W-1:0] rad);
    logic [DIST_W-1:0] root;
    logic [DIST_W-1:0] cand;
    logic [RAD_W+1:0]  sq;
    root = '0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      cand = root | (DIST_W'(1) << b);
      sq = {35'd0, cand} * {35'd0, cand};
      if (sq <= {2'b00, rad}) root = cand;
    end
    return root;
  endfunction

  task automatic advance_odometer(input logic act, input logic [POS_W-1:0] x,
                                  input logic [POS_W-1:0] y,
                                  input logic [YAW_W-1:0] yaw,
                                  output odo_totals_t res);
    logic [POS_W:0]    dx;
    logic [POS_W:0]    dy;
    logic [RAD_W-1:0]  ax;
    logic [RAD_W-1:0]  ay;
    logic [DIST_W-1:0] step_dist;
    logic [YAW_W-1:0]  dyaw;
    logic [YAW_W:0]    rot;
    logic [LEN_W:0]    lsum;
    logic [ROT_W:0]    rsum;
    res.taken = 1'b0;
    if (act == ACT_NEW_ROUTE) begin
      length_total   = '0;
      rotation_total = '0;
    end else begin
      dx = {x[POS_W-1], x} - {kept_x[POS_W-1], kept_x};
      dy = {y[POS_W-1], y} - {kept_y[POS_W-1], kept_y};
      ax = {33'd0, (dx[POS_W] ? (~dx + 1'b1) : dx)};
      ay = {33'd0, (dy[POS_W] ? (~dy + 1'b1) : dy)};
      step_dist = floor_root(ax * ax + ay * ay);
      dyaw = yaw - kept_yaw;
      rot  = (dyaw <= HALF_TURN) ? {1'b0, dyaw} : (17'h10000 - {1'b0, dyaw});
      if (step_dist > {17'd0, threshold}) begin
        lsum = {1'b0, length_total} + {16'd0, step_dist};
        rsum = {1'b0, rotation_total} + {24'd0, rot};
        length_total   = lsum[LEN_W] ? '1 : lsum[LEN_W-1:0];
        rotation_total = rsum[ROT_W] ? '1 : rsum[ROT_W-1:0];
        kept_x   = x;
        kept_y   = y;
        kept_yaw = yaw;
        res.taken = 1'b1;
      end
    end
    res.length   = length_total;
    res.rotation = rotation_total;
  endtask

  initial fail_total = 0;

  assign pending_results = expected_totals.size();

  always @(posedge clk) begin
    odo_totals_t want;
    if (rst) begin
      kept_x         = '0;
      kept_y         = '0;
      kept_yaw       = '0;
      length_total   = '0;
      rotation_total = '0;
      threshold      = THR_RESET;
      expected_totals.delete();
    end else begin
      if (cfg_wr_en) threshold = cfg_wr_data;
      if (in_valid && in_ready) begin
        advance_odometer(in_action, in_x, in_y, in_yaw, want);
        expected_totals.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (expected_totals.size() == 0) begin
          $error("totals request with nothing expected");
          fail_total++;
        end else begin
          want = expected_totals.pop_front();
          if (out_length !== want.length) begin
            $error("total_length expected %0d got %0d", want.length, out_length);
            fail_total++;
          end
          if (out_rotation !== want.rotation) begin
            $error("total_rotation expected %0d got %0d", want.rotation, out_rotation);
            fail_total++;
          end
          if (out_taken !== want.taken) begin
            $error("sample_taken expected %0d got %0d", want.taken, out_taken);
            fail_total++;
          end
        end
      end
    end
  end

endmodule

/* verif/path_length_rotation_odometer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_length_rotation_odometer_tb
// drives pose samples and new-route requests through the odometer under
// random gaps and back-pressure across several threshold settings; a
// checker beside the block predicts and compares every totals request
// ----------------------------------------------------------------------------
module path_length_rotation_odometer_tb;

  import plro_pkg::*;
  import plro_tb_pkg::*;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 212;
  localparam int DRAIN_CYCLES = 60;     // idle margin after the last result is taken
  localparam int HOLD_CYCLES  = 300;    // long receiver stall that backs up into the sender
  localparam int TIMEOUT_NS   = 20_000_000;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [THR_W-1:0] cfg_wr_data;

  plro_in_if  pose_ch ();
  plro_out_if totals_ch ();

  int fail_total;
  int pending_results;

  // idling controls shared by the sender task and the receiver process
  bit tx_steady;
  bit rx_steady;
  int rx_hold;

  // random walk of the pose that the sender offers
  logic [POS_W-1:0] cur_x;
  logic [POS_W-1:0] cur_y;
  logic [YAW_W-1:0] cur_yaw;
  int               thr_now;
  int               span;
  int               pick;
  logic [THR_W-1:0] thr_list[PHASES];

  path_length_rotation_odometer DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pose_in     (pose_ch),
    .totals_out  (totals_ch)
  );

  plro_totals_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (pose_ch.valid),
    .in_ready        (pose_ch.ready),
    .in_action       (pose_ch.action),
    .in_x            (pose_ch.pose_x),
    .in_y            (pose_ch.pose_y),
    .in_yaw          (pose_ch.pose_yaw),
    .out_valid       (totals_ch.valid),
    .out_ready       (totals_ch.ready),
    .out_length      (totals_ch.total_length),
    .out_rotation    (totals_ch.total_rotation),
    .out_taken       (totals_ch.sample_taken),
    .fail_total      (fail_total),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // offer one request, with an optional random gap in front of it
  task automatic send_request(input odo_action_t act, input logic [POS_W-1:0] x,
                              input logic [POS_W-1:0] y, input logic [YAW_W-1:0] yaw);
    while (!tx_steady && ($urandom_range(0, 99) < 28)) begin
      pose_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pose_ch.valid    <= 1'b1;
    pose_ch.action   <= act;
    pose_ch.pose_x   <= x;
    pose_ch.pose_y   <= y;
    pose_ch.pose_yaw <= yaw;
    @(posedge clk);
    while (!pose_ch.ready) @(posedge clk);
  endtask

  // stop offering and let every outstanding request come back
  task automatic pause_for_idle();
    pose_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_results == 0);
    repeat (4) @(posedge clk);
  endtask

  // receiver: random stalls, a counted long hold-off on request
  initial begin
    totals_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        totals_ch.ready <= 1'b0;
        rx_hold--;
      end else begin
        totals_ch.ready <= rx_steady || ($urandom_range(0, 99) >= 28);
      end
    end
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("[path_length_rotation_odometer] ERROR");
    $finish;
  end

  initial begin
    rst              <= 1'b1;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    pose_ch.valid    <= 1'b0;
    pose_ch.action   <= ACT_SAMPLE;
    pose_ch.pose_x   <= '0;
    pose_ch.pose_y   <= '0;
    pose_ch.pose_yaw <= '0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    rx_hold   = 0;
    cur_x     = '0;
    cur_y     = '0;
    cur_yaw   = '0;

    thr_list[0] = 16'd0;
    thr_list[1] = 16'hFFFF;
    thr_list[2] = 16'($urandom_range(0, 65535));
    thr_list[3] = 16'd1;
    thr_list[4] = 16'($urandom_range(2, 200));
    thr_list[5] = 16'd7;
    thr_list[6] = 16'($urandom_range(0, 65535));
    thr_list[7] = 16'd300;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at the reset threshold of 7
    send_request(ACT_SAMPLE, 32'd0, 32'd0, 16'd0);           // no motion at all
    send_request(ACT_SAMPLE, 32'd7, 32'd0, 16'd0);           // exactly on threshold
    send_request(ACT_SAMPLE, 32'd8, 32'd0, HALF_TURN);       // just over, half turn
    send_request(ACT_SAMPLE, 32'd8, 32'd20, 16'h0001);       // turn the short way back
    send_request(ACT_SAMPLE, 32'd11, 32'd24, 16'h0001);      // 3-4-5 step of five, dropped
    send_request(ACT_SAMPLE, 32'd8, 32'd28, 16'hFFFF);       // yaw wraps through zero
    send_request(ACT_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF);
    send_request(ACT_SAMPLE, 32'h8000_0000, 32'h8000_0000, 16'h8001); // widest step
    send_request(ACT_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0000);
    send_request(ACT_NEW_ROUTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(ACT_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000);
    send_request(ACT_SAMPLE, 32'hFFFF_FFF0, 32'h0000_0010, 16'h4000);
    send_request(ACT_NEW_ROUTE, 32'd0, 32'd0, 16'd0);
    send_request(ACT_SAMPLE, 32'h0001_0000, 32'hFFFF_0000, 16'h0123);
    cur_x   = 32'h0001_0000;
    cur_y   = 32'hFFFF_0000;
    cur_yaw = 16'h0123;

    for (int ph = 0; ph < PHASES; ph++) begin
      // threshold changes only with the block drained
      pause_for_idle();
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= thr_list[ph];
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      thr_now = int'(thr_list[ph]);

      // one phase free of idling on both sides
      tx_steady = (ph == 3);
      rx_steady = (ph == 3);
      // receiver holds off while the sender keeps pushing
      if (ph == 1) rx_hold = HOLD_CYCLES;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) pause_for_idle();
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          send_request(ACT_NEW_ROUTE, $urandom, $urandom, 16'($urandom_range(0, 65535)));
        end else begin
          if (pick < 15) begin
            // anywhere in the plane
            cur_x = $urandom;
            cur_y = $urandom;
          end else if (pick < 60) begin
            // steps around the threshold
            span  = thr_now + 4;
            cur_x = cur_x + (int'($urandom_range(0, 2 * span)) - span);
            cur_y = cur_y + (int'($urandom_range(0, 2 * span)) - span);
          end else begin
            cur_x = cur_x + (int'($urandom_range(0, 1 << 21)) - (1 << 20));
            cur_y = cur_y + (int'($urandom_range(0, 1 << 21)) - (1 << 20));
          end
          if ($urandom_range(0, 1) == 0)
            cur_yaw = 16'($urandom_range(0, 65535));
          else
            cur_yaw = cur_yaw + 16'(int'($urandom_range(0, 600)) - 300);
          send_request(ACT_SAMPLE, cur_x, cur_y, cur_yaw);
        end
      end
    end

    // drain and give the verdict
    pose_ch.valid <= 1'b0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    @(posedge clk);
    wait (pending_results == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_total == 0 && pending_results == 0) begin
      $display("[path_length_rotation_odometer] OK");
    end else begin
      $display("[path_length_rotation_odometer] ERROR");
    end
    $finish;
  end

endmodule

/* path_length_rotation_odometer.f */
rtl/plro_pkg.sv
rtl/plro_if.sv
rtl/plro_ctrl.sv
rtl/plro_dp.sv
rtl/path_length_rotation_odometer.sv
verif/plro_tb_pkg.sv
verif/plro_totals_checker.sv
verif/path_length_rotation_odometer_tb.sv
